@@ rtl/ook_frame_transmitter_macros.svh @@
// ----------------------------------------------------------------------------
// ook frame transmitter assertion macros
// concurrent check helpers, removed when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef OOK_FRAME_TRANSMITTER_MACROS_SVH
`define OOK_FRAME_TRANSMITTER_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, held off during reset
`define OOKT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ookt assertion failed");

// next-cycle implication, held off during reset
`define OOKT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ookt assertion failed");

`else

`define OOKT_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define OOKT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/ookt_pkg.sv @@
// ----------------------------------------------------------------------------
// ookt_pkg
// shared types and constants of the ook frame transmitter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ookt_pkg;

    localparam logic [7:0] SYNC_BYTE = 8'hAA;

    // job queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // byte slot being serialised
    typedef enum logic [2:0] {
        PH_SYNC0,
        PH_SYNC1,
        PH_LEN,
        PH_DATA,
        PH_CKSUM
    } ookt_phase_t;

    // one classified transaction: which bytes to send and their values
    typedef struct packed {
        logic       has_header;
        logic       has_data;
        logic       has_cksum;
        logic [7:0] len;
        logic [7:0] data;
        logic [7:0] sum;
    } ookt_job_t;

endpackage

@@ rtl/ookt_front.sv @@
// ----------------------------------------------------------------------------
// ookt_front
// accepts input transactions, tracks frame state and builds byte jobs
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ookt_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               start_of_frame,
    input  logic [7:0]         frame_length,
    input  logic [7:0]         data_byte,
    input  logic               queue_full,
    output logic               push,
    output ookt_pkg::ookt_job_t job
);

    logic [7:0] remaining_reg;
    logic [7:0] remaining_next;
    logic [7:0] sum_reg;
    logic [7:0] sum_next;
    logic       accept;
    logic [7:0] sum_add;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign sum_add  = sum_reg + data_byte;

    always_comb
    begin
        job            = '0;
        job.len        = frame_length;
        job.data       = data_byte;
        push           = 1'b0;
        remaining_next = remaining_reg;
        sum_next       = sum_reg;
        if (accept)
        begin
            priority if (start_of_frame)
            begin
                push           = 1'b1;
                job.has_header = 1'b1;
                if (frame_length == 8'd0)
                begin
                    // empty payload: header then a zero checksum
                    job.has_cksum  = 1'b1;
                    job.sum        = 8'd0;
                    remaining_next = 8'd0;
                    sum_next       = 8'd0;
                end
                else
                begin
                    job.has_data   = 1'b1;
                    job.has_cksum  = (frame_length == 8'd1);
                    job.sum        = data_byte;
                    remaining_next = frame_length - 8'd1;
                    sum_next       = job.has_cksum ? 8'd0 : data_byte;
                end
            end
            else if (remaining_reg != 8'd0)
            begin
                push           = 1'b1;
                job.has_data   = 1'b1;
                job.has_cksum  = (remaining_reg == 8'd1);
                job.sum        = sum_add;
                remaining_next = remaining_reg - 8'd1;
                sum_next       = job.has_cksum ? 8'd0 : sum_add;
            end
            else
            begin
                // no open frame: transaction dropped
                push = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remaining_reg <= 8'd0;
            sum_reg       <= 8'd0;
        end
        else
        begin
            remaining_reg <= remaining_next;
            sum_reg       <= sum_next;
        end
    end

endmodule

@@ rtl/ookt_queue.sv @@
// ----------------------------------------------------------------------------
// ookt_queue
// short job fifo decoupling the front from the serialiser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ookt_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ookt_pkg::ookt_job_t push_job,
    output logic                full,
    input  logic                pop,
    output logic                not_empty,
    output ookt_pkg::ookt_job_t pop_job
);

    ookt_pkg::ookt_job_t                   store [ookt_pkg::QUEUE_DEPTH];
    logic [ookt_pkg::QPTR_W-1:0]           wr_ptr_reg;
    logic [ookt_pkg::QPTR_W-1:0]           wr_ptr_next;
    logic [ookt_pkg::QPTR_W-1:0]           rd_ptr_reg;
    logic [ookt_pkg::QPTR_W-1:0]           rd_ptr_next;
    logic [ookt_pkg::QCNT_W-1:0]           count_reg;
    logic [ookt_pkg::QCNT_W-1:0]           count_next;
    logic                                  do_push;
    logic                                  do_pop;

    localparam logic [ookt_pkg::QPTR_W-1:0] LAST_PTR = ookt_pkg::QPTR_W'(ookt_pkg::QUEUE_DEPTH - 1);
    localparam logic [ookt_pkg::QCNT_W-1:0] FULL_CNT = ookt_pkg::QCNT_W'(ookt_pkg::QUEUE_DEPTH);

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_job   = store[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ rtl/ookt_back.sv @@
// ----------------------------------------------------------------------------
// ookt_back
// serialises queued jobs into bit periods, msb first, with an output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ook_frame_transmitter_macros.svh"

module ookt_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_valid,
    input  ookt_pkg::ookt_job_t job_in,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                carrier_on,
    output logic                frame_end,
    output logic                last
);

    ookt_pkg::ookt_job_t  job_reg;
    ookt_pkg::ookt_phase_t phase_reg;
    ookt_pkg::ookt_phase_t phase_next;
    ookt_pkg::ookt_phase_t phase_after;
    ookt_pkg::ookt_phase_t phase_first;
    logic [2:0]           bit_reg;
    logic [2:0]           bit_next;
    logic                 busy_reg;
    logic                 busy_next;
    logic                 out_valid_reg;
    logic                 carrier_reg;
    logic                 frame_end_reg;
    logic                 last_reg;
    logic                 advance;
    logic                 emit;
    logic                 job_done;
    logic                 final_bit;
    logic                 load;
    logic [7:0]           cur_byte;
    logic                 in_cksum;
    logic                 in_len;
    logic                 stalled;

    assign advance   = !out_valid_reg || out_ready;
    assign emit      = busy_reg && advance;
    assign final_bit = emit && (bit_reg == 3'd0) && job_done;
    assign load      = job_valid && (!busy_reg || final_bit);
    assign pop       = load;

    // next state: byte slot order within a job, bit position and busy flag
    always_comb
    begin
        phase_first = job_in.has_header ? ookt_pkg::PH_SYNC0 : ookt_pkg::PH_DATA;
        phase_after = phase_reg;
        job_done    = 1'b0;
        unique case (phase_reg)
            ookt_pkg::PH_SYNC0: phase_after = ookt_pkg::PH_SYNC1;
            ookt_pkg::PH_SYNC1: phase_after = ookt_pkg::PH_LEN;
            ookt_pkg::PH_LEN:
            begin
                phase_after = job_reg.has_data ? ookt_pkg::PH_DATA : ookt_pkg::PH_CKSUM;
            end
            ookt_pkg::PH_DATA:
            begin
                phase_after = ookt_pkg::PH_CKSUM;
                job_done    = !job_reg.has_cksum;
            end
            ookt_pkg::PH_CKSUM: job_done = 1'b1;
            default:            job_done = 1'b1;
        endcase

        phase_next = phase_reg;
        bit_next   = bit_reg;
        busy_next  = busy_reg;
        if (load)
        begin
            phase_next = phase_first;
            bit_next   = 3'd7;
            busy_next  = 1'b1;
        end
        else if (emit)
        begin
            bit_next = bit_reg - 3'd1;
            if (bit_reg == 3'd0)
            begin
                phase_next = phase_after;
                busy_next  = !job_done;
            end
        end
    end

    // outputs: byte under transmission
    always_comb
    begin
        unique case (phase_reg)
            ookt_pkg::PH_SYNC0: cur_byte = ookt_pkg::SYNC_BYTE;
            ookt_pkg::PH_SYNC1: cur_byte = ookt_pkg::SYNC_BYTE;
            ookt_pkg::PH_LEN:   cur_byte = job_reg.len;
            ookt_pkg::PH_DATA:  cur_byte = job_reg.data;
            ookt_pkg::PH_CKSUM: cur_byte = job_reg.sum;
            default:            cur_byte = 8'd0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            job_reg <= job_in;
        end
        if (emit)
        begin
            carrier_reg   <= cur_byte[bit_reg];
            frame_end_reg <= (phase_reg == ookt_pkg::PH_CKSUM) && (bit_reg == 3'd0);
            last_reg      <= (bit_reg == 3'd0) && job_done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= ookt_pkg::PH_SYNC0;
            bit_reg       <= 3'd7;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            bit_reg   <= bit_next;
            busy_reg  <= busy_next;
            if (advance)
            begin
                out_valid_reg <= emit;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign carrier_on = carrier_reg;
    assign frame_end  = frame_end_reg;
    assign last       = last_reg;

    assign in_cksum = busy_reg && (phase_reg == ookt_pkg::PH_CKSUM);
    assign in_len   = busy_reg && (phase_reg == ookt_pkg::PH_LEN);
    assign stalled  = busy_reg && out_valid_reg && !out_ready;

    `OOKT_ASSERT_IMPLY(a_end_is_last, clk, rst_n, out_valid_reg && frame_end_reg, last_reg)
    `OOKT_ASSERT_IMPLY(a_cksum_owned, clk, rst_n, in_cksum, job_reg.has_cksum)
    `OOKT_ASSERT_IMPLY(a_len_has_hdr, clk, rst_n, in_len, job_reg.has_header)
    `OOKT_ASSERT_NEXT(a_stall_bit, clk, rst_n, stalled, busy_reg && $stable(bit_reg))
    `OOKT_ASSERT_NEXT(a_stall_phase, clk, rst_n, stalled, busy_reg && $stable(phase_reg))

endmodule

@@ rtl/ook_frame_transmitter.sv @@
// ----------------------------------------------------------------------------
// ook_frame_transmitter
// on-off-keyed frame serialiser: sync, length, payload and checksum, msb first
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake              payload
//   input     in         in_valid / in_ready    start_of_frame, frame_length, data_byte
//   output    out        out_valid / out_ready  carrier_on, frame_end, last
//
// one output transaction per clock while the serialiser is busy and out_ready
// is high; a payload transaction sends one or two bytes and a start transaction
// four or five, through the single bit serialiser in the back end
// the front end accepts a transaction per cycle while the two-entry job queue
// has room; data with no frame open is accepted and dropped at once
// reset clears frame state, the queue and the output valid flag; no clearing pass
// a low out_ready freezes the serialiser and, once the queue fills, in_ready
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ook_frame_transmitter
(
    input  logic       clk,
    input  logic       rst_n,
    // input channel
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       start_of_frame,
    input  logic [7:0] frame_length,
    input  logic [7:0] data_byte,
    // output channel
    output logic       out_valid,
    input  logic       out_ready,
    output logic       carrier_on,
    output logic       frame_end,
    output logic       last
);

    // classified job from the front end
    ookt_pkg::ookt_job_t front_job;
    logic                front_push;
    // queue state seen by both sides
    logic                queue_full;
    logic                queue_not_empty;
    ookt_pkg::ookt_job_t back_job;
    logic                back_pop;

    // front: frame tracking, running checksum and transaction classification
    ookt_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .start_of_frame (start_of_frame),
        .frame_length   (frame_length),
        .data_byte      (data_byte),
        .queue_full     (queue_full),
        .push           (front_push),
        .job            (front_job)
    );

    // job queue so each side stalls independently
    ookt_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_push),
        .push_job  (front_job),
        .full      (queue_full),
        .pop       (back_pop),
        .not_empty (queue_not_empty),
        .pop_job   (back_job)
    );

    // back: bit serialiser with registered output
    ookt_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (queue_not_empty),
        .job_in     (back_job),
        .pop        (back_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .carrier_on (carrier_on),
        .frame_end  (frame_end),
        .last       (last)
    );

endmodule

@@ sim/tb_ook_frame_transmitter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ook_frame_transmitter
// self-checking bench for the ook frame serialiser: a directed table walks
// the frame corner cases, then random frames, abandoned frames and stray data
// run against a bit-level predictor, with bursty input and a stalling receiver
// ----------------------------------------------------------------------------

module tb_ook_frame_transmitter;

    // one bit period on the output channel
    typedef struct packed {
        logic carrier_on;
        logic frame_end;
        logic last;
    } symbol_t;

    // one input transaction; typed rows carry their byte stream by hand
    typedef struct packed {
        logic        sof;
        logic [7:0]  len;
        logic [7:0]  data;
        logic        typed;
        logic [2:0]  nbytes;
        logic [39:0] bytes;      // first byte in the top eight bits
        logic        cksum_end;  // last listed byte is the checksum
    } stim_row_t;

    localparam int CLK_HALF       = 5;
    localparam int RANDOM_ITEMS   = 110;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int DRAIN_CYCLES   = 64;

    // directed table: extremes, zero and one length, drops, abandonment, wrap
    localparam int N_DIRECTED = 21;
    localparam stim_row_t DIRECTED_ROWS [0:N_DIRECTED-1] = '{
        // data straight after reset, no frame open: dropped
        '{1'b0, 8'h00, 8'hFF, 1'b1, 3'd0, 40'h00_00_00_00_00, 1'b0},
        // zero length: header and a zero checksum, data byte ignored
        '{1'b1, 8'h00, 8'hFF, 1'b1, 3'd4, 40'hAA_AA_00_00_00, 1'b1},
        // frame closed again, so this one is dropped
        '{1'b0, 8'hFF, 8'h00, 1'b1, 3'd0, 40'h00_00_00_00_00, 1'b0},
        // length one, all ones and all zeros
        '{1'b1, 8'h01, 8'hFF, 1'b1, 3'd5, 40'hAA_AA_01_FF_FF, 1'b1},
        '{1'b1, 8'h01, 8'h00, 1'b1, 3'd5, 40'hAA_AA_01_00_00, 1'b1},
        // longest length, left open
        '{1'b1, 8'hFF, 8'hFF, 1'b1, 3'd4, 40'hAA_AA_FF_FF_00, 1'b0},
        '{1'b0, 8'h00, 8'h80, 1'b0, 3'd0, 40'h0, 1'b0},
        // new start abandons the open frame, no checksum for it
        '{1'b1, 8'h02, 8'h7F, 1'b1, 3'd4, 40'hAA_AA_02_7F_00, 1'b0},
        // sum wraps to zero
        '{1'b0, 8'h55, 8'h81, 1'b1, 3'd2, 40'h81_00_00_00_00, 1'b1},
        '{1'b1, 8'h03, 8'h55, 1'b0, 3'd0, 40'h0, 1'b0},
        '{1'b0, 8'h00, 8'hAA, 1'b0, 3'd0, 40'h0, 1'b0},
        '{1'b0, 8'hFF, 8'h01, 1'b0, 3'd0, 40'h0, 1'b0},
        // two full bytes wrap to 0xFE
        '{1'b1, 8'h02, 8'hFF, 1'b0, 3'd0, 40'h0, 1'b0},
        '{1'b0, 8'h00, 8'hFF, 1'b1, 3'd2, 40'hFF_FE_00_00_00, 1'b1},
        // stray data once the frame has its checksum
        '{1'b0, 8'hAA, 8'h5A, 1'b1, 3'd0, 40'h00_00_00_00_00, 1'b0},
        // open a long frame, then abandon it for a zero-length one
        '{1'b1, 8'h80, 8'h01, 1'b0, 3'd0, 40'h0, 1'b0},
        '{1'b1, 8'h00, 8'h00, 1'b1, 3'd4, 40'hAA_AA_00_00_00, 1'b1},
        '{1'b1, 8'h04, 8'h01, 1'b0, 3'd0, 40'h0, 1'b0},
        '{1'b0, 8'h7F, 8'h02, 1'b0, 3'd0, 40'h0, 1'b0},
        '{1'b0, 8'h00, 8'h04, 1'b0, 3'd0, 40'h0, 1'b0},
        '{1'b0, 8'hC3, 8'h08, 1'b0, 3'd0, 40'h0, 1'b0}
    };

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic       start_of_frame;
    logic [7:0] frame_length;
    logic [7:0] data_byte;
    logic       out_valid;
    logic       out_ready;
    logic       carrier_on;
    logic       frame_end;
    logic       last;

    // frame state of the predictor
    logic [7:0] payload_left;
    logic [7:0] payload_sum;

    symbol_t   predicted_symbols[$];
    symbol_t   expected_symbols[$];
    stim_row_t stim_rows[$];
    stim_row_t cur_row;

    int n_accepted;
    int n_checked;
    int n_errors;

    ook_frame_transmitter u_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .start_of_frame (start_of_frame),
        .frame_length   (frame_length),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .carrier_on     (carrier_on),
        .frame_end      (frame_end),
        .last           (last)
    );

    always
    begin
        clk = 1'b1;
        #CLK_HALF;
        clk = 1'b0;
        #CLK_HALF;
    end

    // eight bit symbols, msb first; frame_end on the lsb of a checksum
    function automatic void push_byte(input logic [7:0] b, input logic is_cksum);
        symbol_t s;
        for (int i = 7; i >= 0; i--)
        begin
            s.carrier_on = b[i];
            s.frame_end  = is_cksum && (i == 0);
            s.last       = 1'b0;
            predicted_symbols.push_back(s);
        end
    endfunction

    // mark the final symbol of this transaction
    function automatic void mark_last();
        symbol_t s;
        if (predicted_symbols.size() > 0)
        begin
            s = predicted_symbols.pop_back();
            s.last = 1'b1;
            predicted_symbols.push_back(s);
        end
    endfunction

    // bit symbols caused by one accepted transaction, frame state updated
    function automatic void predict_bit_symbols(input logic       sof,
                                                input logic [7:0] len,
                                                input logic [7:0] data);
        logic send_data;
        send_data = 1'b0;
        predicted_symbols.delete();
        if (sof)
        begin
            payload_sum = 8'h00;
            push_byte(ookt_pkg::SYNC_BYTE, 1'b0);
            push_byte(ookt_pkg::SYNC_BYTE, 1'b0);
            push_byte(len, 1'b0);
            payload_left = len;
            if (len == 8'h00)
                push_byte(8'h00, 1'b1);
            else
                send_data = 1'b1;
        end
        else if (payload_left != 8'h00)
        begin
            send_data = 1'b1;
        end
        if (send_data)
        begin
            push_byte(data, 1'b0);
            payload_sum  = payload_sum + data;
            payload_left = payload_left - 8'h01;
            if (payload_left == 8'h00)
            begin
                push_byte(payload_sum, 1'b1);
                payload_sum = 8'h00;
            end
        end
        mark_last();
    endfunction

    // hand-typed byte stream of a directed row replaces the prediction
    function automatic void expand_typed_row(input stim_row_t row);
        predicted_symbols.delete();
        for (int j = 0; j < row.nbytes; j++)
            push_byte(row.bytes[39 - 8*j -: 8], row.cksum_end && (j == row.nbytes - 1));
        mark_last();
    endfunction

    function automatic stim_row_t make_row(input logic       sof,
                                           input logic [7:0] len,
                                           input logic [7:0] data);
        stim_row_t r;
        r = '0;
        r.sof  = sof;
        r.len  = len;
        r.data = data;
        return r;
    endfunction

    // random part: mostly complete frames, some abandoned ones, some stray data
    task automatic build_random_stimulus();
        int   counted;
        int   kind;
        int   len;
        int   k;
        logic must_restart;
        counted      = 0;
        must_restart = 1'b0;
        while (counted < RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 9);
            if (must_restart && kind >= 8)
                kind = 0;
            if (kind <= 6)
            begin
                // well-formed frame, mostly short
                if ($urandom_range(0, 7) == 0)
                    len = $urandom_range(7, 20);
                else
                    len = $urandom_range(0, 6);
                stim_rows.push_back(make_row(1'b1, len[7:0], 8'($urandom_range(0, 255))));
                for (int i = 1; i < len; i++)
                    stim_rows.push_back(make_row(1'b0, 8'($urandom_range(0, 255)),
                                                 8'($urandom_range(0, 255))));
                counted      += (len == 0) ? 1 : len;
                must_restart  = 1'b0;
            end
            else if (kind == 7)
            begin
                // broken frame: length 2 to 255, usually cut short by the next start
                len = $urandom_range(2, 255);
                k   = $urandom_range(0, 4);
                stim_rows.push_back(make_row(1'b1, len[7:0], 8'($urandom_range(0, 255))));
                for (int i = 0; i < k; i++)
                    stim_rows.push_back(make_row(1'b0, 8'($urandom_range(0, 255)),
                                                 8'($urandom_range(0, 255))));
                counted      += 1 + k;
                must_restart  = 1'b1;
            end
            else
            begin
                // noise with no frame open, dropped by the block
                k = $urandom_range(1, 3);
                for (int i = 0; i < k; i++)
                    stim_rows.push_back(make_row(1'b0, 8'($urandom_range(0, 255)),
                                                 8'($urandom_range(0, 255))));
                counted += k;
            end
        end
    endtask

    // predict on every accepted input transaction, check every output one
    always @(posedge clk)
    begin
        symbol_t exp_sym;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                predict_bit_symbols(start_of_frame, frame_length, data_byte);
                if (cur_row.typed)
                    expand_typed_row(cur_row);
                while (predicted_symbols.size() > 0)
                    expected_symbols.push_back(predicted_symbols.pop_front());
                n_accepted++;
            end
            if (out_valid && out_ready)
            begin
                if (expected_symbols.size() == 0)
                begin
                    $display("%0t: expected no symbol, actual carrier_on=%b frame_end=%b last=%b",
                             $time, carrier_on, frame_end, last);
                    n_errors++;
                end
                else
                begin
                    exp_sym = expected_symbols.pop_front();
                    if (carrier_on !== exp_sym.carrier_on)
                    begin
                        $display("%0t: symbol %0d carrier_on: expected %b, actual %b",
                                 $time, n_checked, exp_sym.carrier_on, carrier_on);
                        n_errors++;
                    end
                    if (frame_end !== exp_sym.frame_end)
                    begin
                        $display("%0t: symbol %0d frame_end: expected %b, actual %b",
                                 $time, n_checked, exp_sym.frame_end, frame_end);
                        n_errors++;
                    end
                    if (last !== exp_sym.last)
                    begin
                        $display("%0t: symbol %0d last: expected %b, actual %b",
                                 $time, n_checked, exp_sym.last, last);
                        n_errors++;
                    end
                end
                n_checked++;
            end
        end
    end

    // receiver: stall mode is redrawn at random from four patterns, plus one long hold-off
    // once traffic is flowing, so the job queue fills and in_ready drops
    initial
    begin
        int  cyc;
        int  mode;
        int  hold_left;
        logic hold_done;
        cyc       = 0;
        mode      = 0;
        hold_left = 0;
        hold_done = 1'b0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            cyc++;
            if (cyc % 100 == 0)
                mode = $urandom_range(0, 3);
            if (!hold_done && n_accepted >= 60)
            begin
                hold_left = HOLDOFF_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    2:       out_ready <= !((cyc % 5 == 0) || (cyc % 7 == 0));
                    default: out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // sender and end of run
    initial
    begin
        stim_row_t row;
        int        burst;
        int        gap;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        start_of_frame = 1'b0;
        frame_length   = 8'h00;
        data_byte      = 8'h00;
        cur_row        = '0;
        payload_left   = 8'h00;
        payload_sum    = 8'h00;
        n_accepted     = 0;
        n_checked      = 0;
        n_errors       = 0;

        for (int i = 0; i < N_DIRECTED; i++)
            stim_rows.push_back(DIRECTED_ROWS[i]);
        build_random_stimulus();

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // bursts of back-to-back transactions with random gaps between them
        while (stim_rows.size() > 0)
        begin
            burst = $urandom_range(1, 12);
            for (int k = 0; k < burst && stim_rows.size() > 0; k++)
            begin
                row = stim_rows.pop_front();
                @(negedge clk);
                in_valid       <= 1'b1;
                start_of_frame <= row.sof;
                frame_length   <= row.len;
                data_byte      <= row.data;
                cur_row        <= row;
                @(posedge clk);
                while (!in_ready)
                    @(posedge clk);
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        in_valid <= 1'b0;

        // drain, then a short quiet stretch to catch stray symbols
        while (expected_symbols.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_symbols.size() != 0)
        begin
            $display("%0t: %0d expected symbols never arrived", $time,
                     expected_symbols.size());
            n_errors++;
        end
        if (n_errors == 0)
            $display("ook_frame_transmitter test passed");
        else
            $display("ook_frame_transmitter test failed");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("ook_frame_transmitter test failed");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/ookt_pkg.sv
rtl/ookt_front.sv
rtl/ookt_queue.sv
rtl/ookt_back.sv
rtl/ook_frame_transmitter.sv
sim/tb_ook_frame_transmitter.sv
